// ===== hw/rtl/brms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_pkg: shared constants and types of the block RMS meter
// Widths of the accumulator, the long divider and the square-root unit,
// plus the controller state type and the command/status bundles.
// ----------------------------------------------------------------------------
package brms_pkg;

   // Block configuration
   localparam int MAX_COUNT    = 65536;
   localparam int SAMPLE_WIDTH = 16;

   // Port field widths
   localparam int IN_W       = 16;
   localparam int RMS_W      = 16;
   localparam int OUT_CNT_W  = 17;
   localparam int RSP_DATA_W = 40;

   // Datapath widths
   localparam int CNT_W      = $clog2(MAX_COUNT + 1);
   localparam int SQ_W       = 2 * SAMPLE_WIDTH - 1;
   localparam int SUM_W      = SQ_W + $clog2(MAX_COUNT);
   localparam int ROOT_W     = SAMPLE_WIDTH;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 1;
   localparam int CAND_W     = ROOT_W + 3;
   localparam int DIV_STEPS  = SUM_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_LOAD,
      ST_DIVIDE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== hw/rtl/block_rms_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sample per cycle while a block is being accumulated.
// After the transfer of the last sample, rsp_tvalid rises once the controller
//   has run drain, load, the restoring divider (one step per sum bit, 47),
//   root load, the root (one step per root bit, 16) and the hand-off.
// req_tready is low through all of these phases, and longer if the result waits.
// Reset (synchronous, active high) clears the accumulator, count and flags.
// ----------------------------------------------------------------------------
// block_rms_meter: RMS of blocks of signed Q4.12 samples
// Sums squares per block; on the last sample divides by the count and takes
// the floor square root, giving the RMS in Q4.12 with count and overflow flag.
// ----------------------------------------------------------------------------
module block_rms_meter (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [15:0]  req_tdata,   // [15:0] sample
   input  wire          req_tlast,   // last_sample
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [39:0]  rsp_tdata,   // [15:0] rms, [32:16] sample_count, [39:33] zero
   output logic         rsp_tuser    // too_long
);

   brms_pkg::cmd_type cmd;
   brms_pkg::sts_type sts;
   logic              req_xfer;

   assign req_xfer = req_tvalid && req_tready;

   brms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   brms_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_xfer   (req_xfer),
      .req_sample (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // No new sample right after a block ends
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("sample taken while block result is computed");

   // Result register is only loaded when it is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result overwritten before transfer");

   // A new result only appears while input is held off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while accumulating");

   // Divider and root never step together
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_step && cmd.root_step))
      else $error("divider and root active together");

endmodule
`default_nettype wire

// ===== hw/rtl/brms_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_ctrl: sequencer of the block RMS meter
// Takes samples while accumulating; after the last sample of a block it runs
// the divider and the square-root unit step by step and hands off the result.
// ----------------------------------------------------------------------------
module brms_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   input  wire              req_tlast,
   output logic             req_tready,
   input  brms_pkg::sts_type sts,
   output brms_pkg::cmd_type cmd
);

   brms_pkg::state_type state_ff, state_in;
   logic [brms_pkg::STEP_W-1:0] step_ff, step_in;
   logic last_xfer;

   assign last_xfer = req_tvalid && req_tready && req_tlast;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brms_pkg::ST_ACCUM: begin
            if (last_xfer) state_in = brms_pkg::ST_DRAIN;
         end
         brms_pkg::ST_DRAIN:      state_in = brms_pkg::ST_LOAD;
         brms_pkg::ST_LOAD:       state_in = brms_pkg::ST_DIVIDE;
         brms_pkg::ST_DIVIDE: begin
            if (step_ff == brms_pkg::STEP_W'(brms_pkg::DIV_STEPS - 1))
               state_in = brms_pkg::ST_ROOT_LOAD;
         end
         brms_pkg::ST_ROOT_LOAD:  state_in = brms_pkg::ST_ROOT;
         brms_pkg::ST_ROOT: begin
            if (step_ff == brms_pkg::STEP_W'(brms_pkg::ROOT_STEPS - 1))
               state_in = brms_pkg::ST_EMIT;
         end
         brms_pkg::ST_EMIT: begin
            if (sts.out_free) state_in = brms_pkg::ST_ACCUM;
         end
         default:                 state_in = brms_pkg::ST_ACCUM;
      endcase
   end

   // Step counter for the divide and root phases
   always_comb begin
      step_in = '0;
      if (state_ff == brms_pkg::ST_DIVIDE && state_in == brms_pkg::ST_DIVIDE) begin
         step_in = step_ff + 1'b1;
      end else if (state_ff == brms_pkg::ST_ROOT && state_in == brms_pkg::ST_ROOT) begin
         step_in = step_ff + 1'b1;
      end
   end

   // Outputs
   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         brms_pkg::ST_ACCUM:     req_tready     = 1'b1;
         brms_pkg::ST_LOAD:      cmd.div_load   = 1'b1;
         brms_pkg::ST_DIVIDE:    cmd.div_step   = 1'b1;
         brms_pkg::ST_ROOT_LOAD: cmd.root_load  = 1'b1;
         brms_pkg::ST_ROOT:      cmd.root_step  = 1'b1;
         brms_pkg::ST_EMIT:      cmd.out_load   = sts.out_free;
         default:                req_tready     = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brms_pkg::ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/brms_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_dp: datapath of the block RMS meter
// Squarer stage, accumulator that stops at the maximum count and flags overflow,
// restoring long divider (one quotient bit per step), digit-by-digit square
// root (one root bit per step) and the result register.
// ----------------------------------------------------------------------------
module brms_dp (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_xfer,
   input  wire  [brms_pkg::IN_W-1:0]        req_sample,
   input  brms_pkg::cmd_type                cmd,
   output brms_pkg::sts_type                sts,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [brms_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser
);

   localparam int SW = brms_pkg::SAMPLE_WIDTH;

   // ---------------- squarer stage ----------------
   logic [SW-1:0]               raw, mag;
   logic [2*SW-1:0]             sq_full;
   logic                        s1_valid_ff;
   logic [brms_pkg::SQ_W-1:0]   sq_ff;

   assign raw     = req_sample[SW-1:0];
   assign mag     = raw[SW-1] ? (~raw + 1'b1) : raw;
   assign sq_full = mag * mag;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= req_xfer;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) sq_ff <= sq_full[brms_pkg::SQ_W-1:0];
   end

   // ---------------- accumulator ----------------
   logic [brms_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [brms_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       ovf_ff, ovf_in;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.div_load) begin
         sum_in = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (s1_valid_ff) begin
         if (cnt_ff == brms_pkg::CNT_W'(brms_pkg::MAX_COUNT)) begin
            ovf_in = 1'b1;
         end else begin
            sum_in = sum_ff + brms_pkg::SUM_W'(sq_ff);
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   // ---------------- restoring divider ----------------
   logic [brms_pkg::SUM_W-1:0] quo_ff;
   logic [brms_pkg::CNT_W-1:0] rem_ff;
   logic [brms_pkg::CNT_W-1:0] dvs_ff;
   logic                       tl_ff;
   logic [brms_pkg::CNT_W:0]   div_shift, div_diff;
   logic                       div_ge;

   assign div_shift = {rem_ff, quo_ff[brms_pkg::SUM_W-1]};
   assign div_diff  = div_shift - {1'b0, dvs_ff};
   assign div_ge    = div_shift >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
         dvs_ff <= cnt_ff;
         tl_ff  <= ovf_ff;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[brms_pkg::SUM_W-2:0], div_ge};
         rem_ff <= div_ge ? div_diff[brms_pkg::CNT_W-1:0]
                          : div_shift[brms_pkg::CNT_W-1:0];
      end
   end

   // ---------------- square root ----------------
   logic [brms_pkg::RAD_W-1:0]  rad_ff;
   logic [brms_pkg::REM_W-1:0]  srem_ff;
   logic [brms_pkg::ROOT_W-1:0] root_ff;
   logic [brms_pkg::CAND_W-1:0] cand, trial, sq_diff;
   logic                        sq_ge;

   assign cand    = {srem_ff, rad_ff[brms_pkg::RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign sq_diff = cand - trial;
   assign sq_ge   = cand >= trial;

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         rad_ff  <= brms_pkg::RAD_W'(quo_ff[brms_pkg::SQ_W-1:0]);
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[brms_pkg::RAD_W-3:0], 2'b00};
         srem_ff <= sq_ge ? sq_diff[brms_pkg::REM_W-1:0] : cand[brms_pkg::REM_W-1:0];
         root_ff <= {root_ff[brms_pkg::ROOT_W-2:0], sq_ge};
      end
   end

   // ---------------- result register ----------------
   logic                               out_valid_ff;
   logic [brms_pkg::RMS_W-1:0]         out_rms_ff;
   logic [brms_pkg::OUT_CNT_W-1:0]     out_cnt_ff;
   logic                               out_tl_ff;

   assign sts.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_rms_ff <= brms_pkg::RMS_W'(root_ff);
         out_cnt_ff <= brms_pkg::OUT_CNT_W'(dvs_ff);
         out_tl_ff  <= tl_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(brms_pkg::RSP_DATA_W - brms_pkg::RMS_W - brms_pkg::OUT_CNT_W){1'b0}},
                        out_cnt_ff, out_rms_ff};
   assign rsp_tuser  = out_tl_ff;

endmodule
`default_nettype wire

// ===== tb/block_rms_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rms_meter_tb: self-checking bench for the block RMS meter
// A table of directed blocks covers the sample extremes and mixed multi-sample
// blocks. It is followed by random blocks of mostly short length. Both stream
// sides stall at random. Each result is checked against its typed table row or
// else an in-bench square-sum / divide / floor-root predictor.
// ----------------------------------------------------------------------------
module block_rms_meter_tb;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 500;
   localparam int IDLE_PERCENT   = 38;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int PLAN_ROWS      = 12;

   // One finished block as reported on the result stream
   typedef struct packed {
      logic [brms_pkg::RMS_W-1:0]     rms;
      logic [brms_pkg::OUT_CNT_W-1:0] count;
      logic                           too_long;
   } rms_result_type;

   // Directed row: a run of identical samples, optionally closing the block
   typedef struct packed {
      logic [brms_pkg::IN_W-1:0]      sample;
      logic [brms_pkg::OUT_CNT_W-1:0] reps;
      logic                           ends_block;
      logic                           typed;
      rms_result_type                 want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample
   logic        req_tlast;   // last_sample
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [15:0] rms, [32:16] sample_count, [39:33] zero
   logic        rsp_tuser;   // too_long

   // Predictor state
   logic [46:0]                    sq_sum;
   logic [brms_pkg::OUT_CNT_W-1:0] samples_held;
   logic                           block_overrun;
   rms_result_type                 rms_results_due[$];

   // Typed expectation attached to the sample now on the bus
   logic           typed_on_bus;
   rms_result_type typed_value;

   logic        calm;
   int          mismatch_count;
   int          quiet_cycles;
   int          random_items;
   int          blk_len;

   localparam logic [brms_pkg::OUT_CNT_W-1:0] FULL =
      brms_pkg::OUT_CNT_W'(brms_pkg::MAX_COUNT);

   stim_row_type plan [0:PLAN_ROWS-1] = '{
      // single-sample blocks right after reset, then the extremes
      '{16'h0000, 17'd1, 1'b1, 1'b1, '{16'h0000, 17'd1, 1'b0}},
      '{16'h8000, 17'd1, 1'b1, 1'b1, '{16'h8000, 17'd1, 1'b0}},
      '{16'h7FFF, 17'd1, 1'b1, 1'b1, '{16'h7FFF, 17'd1, 1'b0}},
      '{16'hFFFF, 17'd1, 1'b1, 1'b1, '{16'h0001, 17'd1, 1'b0}},
      '{16'h0001, 17'd1, 1'b1, 1'b1, '{16'h0001, 17'd1, 1'b0}},
      // multi-sample blocks, checked by the predictor
      '{16'h1000, 17'd3, 1'b0, 1'b0, '0},
      '{16'h0000, 17'd1, 1'b1, 1'b0, '0},
      '{16'h7FFF, 17'd1, 1'b0, 1'b0, '0},
      '{16'h8000, 17'd1, 1'b0, 1'b0, '0},
      '{16'h5A5A, 17'd1, 1'b0, 1'b0, '0},
      '{16'hA5A5, 17'd1, 1'b1, 1'b0, '0},
      // mid-level single sample
      '{16'h0800, 17'd1, 1'b1, 1'b1, '{16'h0800, 17'd1, 1'b0}}
   };

   block_rms_meter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock
   always begin
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
      #HALF_PERIOD;
   end

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Floor square root, one result bit at a time from the top
   function automatic logic [brms_pkg::RMS_W-1:0] floor_sqrt(input logic [46:0] v);
      logic [brms_pkg::RMS_W-1:0] root;
      logic [brms_pkg::RMS_W-1:0] trial;
      longint unsigned            sq;
      root = '0;
      for (int b = brms_pkg::RMS_W - 1; b >= 0; b--) begin
         trial = root | (brms_pkg::RMS_W'(1) << b);
         sq = longint'(trial) * longint'(trial);
         if (sq <= longint'(v))
            root = trial;
      end
      return root;
   endfunction

   // Fold one accepted sample into the running block; queue the result on last
   task automatic track_sample(input logic [brms_pkg::IN_W-1:0] s, input logic last);
      logic [brms_pkg::IN_W-1:0] mag;
      logic [46:0]               mean;
      rms_result_type            res;
      mag = s[brms_pkg::IN_W-1] ? (~s + 1'b1) : s;
      if (samples_held >= FULL) begin
         block_overrun = 1'b1;
      end else begin
         sq_sum = sq_sum + 47'(mag) * 47'(mag);
         samples_held = samples_held + 1'b1;
      end
      if (last) begin
         mean = sq_sum / 47'(samples_held);
         res.rms = floor_sqrt(mean);
         res.count = samples_held;
         res.too_long = block_overrun;
         rms_results_due.push_back(typed_on_bus ? typed_value : res);
         sq_sum = '0;
         samples_held = '0;
         block_overrun = 1'b0;
      end
   endtask

   // Monitor: check results, track accepted samples, watch for a hang
   always @(posedge clock) begin
      rms_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (rms_results_due.size() == 0) begin
               flag_mismatch("result with none due", rsp_tdata, 0);
            end else begin
               want = rms_results_due.pop_front();
               if (rsp_tdata[15:0] !== want.rms)
                  flag_mismatch("rms", rsp_tdata[15:0], want.rms);
               if (rsp_tdata[32:16] !== want.count)
                  flag_mismatch("sample_count", rsp_tdata[32:16], want.count);
               if (rsp_tuser !== want.too_long)
                  flag_mismatch("too_long", rsp_tuser, want.too_long);
               if (rsp_tdata[39:33] !== '0)
                  flag_mismatch("tdata padding", rsp_tdata[39:33], 0);
            end
         end
         if (req_tvalid && req_tready)
            track_sample(req_tdata, req_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("block_rms_meter test failed");
            $finish;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Present one sample, with random gaps, and hold it until the transfer
   task automatic send_sample(input logic [brms_pkg::IN_W-1:0] s, input logic last,
                              input logic typed, input rms_result_type want);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      typed_on_bus = typed && last;
      typed_value  = want;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Sender holds off until every queued result has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (rms_results_due.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [brms_pkg::IN_W-1:0] pick_sample();
      logic [brms_pkg::IN_W-1:0] v;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               3: v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         1: begin
            // low level signal, either sign
            v = brms_pkg::IN_W'($urandom_range(31));
            if ($urandom_range(1) == 1)
               v = ~v + 1'b1;
         end
         default: v = brms_pkg::IN_W'($urandom);
      endcase
      return v;
   endfunction

   // Stimulus
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      calm           = 1'b0;
      typed_on_bus   = 1'b0;
      typed_value    = '0;
      sq_sum         = '0;
      samples_held   = '0;
      block_overrun  = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      random_items   = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < PLAN_ROWS; r++) begin
         for (int k = 0; k < int'(plan[r].reps); k++)
            send_sample(plan[r].sample,
                        plan[r].ends_block && (k == int'(plan[r].reps) - 1),
                        plan[r].typed, plan[r].want);
      end
      wait_results_drained();

      // random blocks, mostly short; a stretch in the middle runs without stalls
      while (random_items < RANDOM_ITEMS) begin
         blk_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                            : $urandom_range(12, 1);
         if ($urandom_range(9) == 0)
            wait_results_drained();
         for (int k = 0; k < blk_len; k++) begin
            send_sample(pick_sample(), k == blk_len - 1, 1'b0, '0);
            random_items++;
            calm = (random_items >= 200) && (random_items < 300);
         end
      end
      calm = 1'b0;

      // drain and let the pipeline settle
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("block_rms_meter test passed");
      else
         $display("block_rms_meter test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/brms_pkg.sv
hw/rtl/brms_ctrl.sv
hw/rtl/brms_dp.sv
hw/rtl/block_rms_meter.sv
tb/block_rms_meter_tb.sv
